FILE: rtl/tzw_pkg.sv
package tzw_pkg;

    localparam int RAW_W = 32;
    localparam int DEG_W = 28;
    localparam int THR_W = 8;
    localparam int HYS_W = 4;
    localparam int IDX_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [THR_W-1:0] HIGH_THR_RST = 8'd50;
    localparam logic [THR_W-1:0] CRIT_THR_RST = 8'd75;
    localparam logic [HYS_W-1:0] HYST_RST = 4'd2;
    localparam logic [THR_W-1:0] MAX_GRAD_RST = 8'd10;
    localparam logic [RAW_W-1:0] INVALID_RST = 32'hFFFF_FFFF;
    localparam logic [3:0] FRAC_MASK = 4'h F;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_THR = 3'd0,
        CFG_CRIT_THR = 3'd1,
        CFG_HYST = 3'd2,
        CFG_MAX_GRAD = 3'd3,
        CFG_INVALID = 3'd4
    } t_cfg_index;

    typedef enum logic [1:0] {
        ZONE_START = 2'd0,
        ZONE_NORMAL = 2'd1,
        ZONE_HIGH = 2'd2,
        ZONE_CRITICAL = 2'd3
    } t_zone;

    typedef enum logic [1:0] {
        ST_JUDGED = 2'd0,
        ST_INVALID = 2'd1,
        ST_REJECTED = 2'd2
    } t_status;

    typedef struct packed {
        t_zone zone;
        logic [DEG_W-1:0] degrees;
    } t_entry;

    function automatic logic [3:0] tenth_of(input logic [3:0] frac);
        logic [7:0] prod;
        begin
            prod = {4'b0, frac & FRAC_MASK} * 8'd10;
            tenth_of = prod[7:4];
        end
    endfunction

    function automatic t_zone next_zone(input t_zone zone, input logic [DEG_W-1:0] deg,
                                        input logic [THR_W-1:0] hi,
                                        input logic [THR_W-1:0] cr,
                                        input logic [HYS_W-1:0] hy);
        logic [THR_W:0] hi_lim;
        logic [THR_W:0] cr_lim;
        logic hi_fall;
        logic cr_fall;
        logic ge_hi;
        logic ge_cr;
        t_zone nz;
        begin
            hi_lim = {1'b0, hi} - {5'b0, hy};
            cr_lim = {1'b0, cr} - {5'b0, hy};
            hi_fall = !hi_lim[THR_W] && (deg <= {{(DEG_W-THR_W){1'b0}}, hi_lim[THR_W-1:0]});
            cr_fall = !cr_lim[THR_W] && (deg <= {{(DEG_W-THR_W){1'b0}}, cr_lim[THR_W-1:0]});
            ge_hi = deg >= {{(DEG_W-THR_W){1'b0}}, hi};
            ge_cr = deg >= {{(DEG_W-THR_W){1'b0}}, cr};
            case (zone)
                ZONE_HIGH: begin
                    if (hi_fall) nz = ZONE_NORMAL;
                    else if (ge_cr) nz = ZONE_CRITICAL;
                    else nz = ZONE_HIGH;
                end
                ZONE_CRITICAL: begin
                    if (hi_fall) nz = ZONE_NORMAL;
                    else if (cr_fall) nz = ZONE_HIGH;
                    else nz = ZONE_CRITICAL;
                end
                default: begin
                    if (ge_cr) nz = ZONE_CRITICAL;
                    else if (ge_hi) nz = ZONE_HIGH;
                    else nz = ZONE_NORMAL;
                end
            endcase
            next_zone = nz;
        end
    endfunction

endpackage

FILE: rtl/tzw_ram.sv
module tzw_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [2**ADDR_W];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/temperature_zone_watcher_core.sv
// Channel   Dir  tdata                               tuser
// s_axis    in   [31:0] raw_reading, zero pad to 32   [1:0] sensor_index
// m_axis    out  zone, zone_changed, whole, tenth     [1:0] sensor_id, [3:2] status
// cfg       in   write enable, 3-bit index, 32-bit data, no read-back
//
// One reading per cycle while the output is not stalled; a result passes
// the s1 and output registers. Sensor state sits in one RAM with a
// registered read; a previous reading's write to the same sensor is forwarded.
// Reset is synchronous; per-sensor valid bits make unwritten entries read as
// start zone and zero degrees, so no clearing pass is needed.
// A stalled output holds the result and the reading behind it; input tready
// drops only while both are held.
module temperature_zone_watcher_core #(
    parameter int NUM_SENSORS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] raw_reading
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] sensor_index
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // [1:0] zone, [2] zone_changed, [30:3] whole_degrees,
                                         // [34:31] tenth_degree, [39:35] zero
    output logic [3:0]  o_m_axis_tuser,  // [1:0] sensor_id, [3:2] status
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int ADDR_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int ENTRY_W = $bits(tzw_pkg::t_entry);
    localparam int DEG_W = tzw_pkg::DEG_W;

    logic [7:0]  r_high_thr;
    logic [7:0]  r_crit_thr;
    logic [3:0]  r_hyst;
    logic [7:0]  r_max_grad;
    logic [31:0] r_invalid;

    logic              r_s1_valid;
    logic [1:0]        r_s1_idx;
    logic [31:0]       r_s1_raw;
    logic              r_s1_fwd;
    tzw_pkg::t_entry   r_fwd_entry;
    logic [2**ADDR_W-1:0] r_vld;

    logic                  r_out_valid;
    logic [1:0]            r_out_id;
    tzw_pkg::t_status      r_out_status;
    tzw_pkg::t_zone        r_out_zone;
    logic                  r_out_changed;
    logic [DEG_W-1:0]      r_out_deg;
    logic [3:0]            r_out_tenth;

    logic                  in_accept;
    logic                  s1_adv;
    logic [ADDR_W-1:0]     in_addr;
    logic [ADDR_W-1:0]     s1_addr;
    logic [ENTRY_W-1:0]    ram_rdata;
    tzw_pkg::t_entry       s1_entry;
    tzw_pkg::t_entry       wr_entry;
    logic                  s1_wr;
    logic                  s1_in_range;
    logic [DEG_W-1:0]      s1_deg;
    logic [DEG_W-1:0]      s1_jump;
    tzw_pkg::t_status      n_status;
    tzw_pkg::t_zone        n_zone;
    logic                  n_changed;

    assign s1_adv = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign in_addr = ADDR_W'(i_s_axis_tuser);
    assign s1_addr = ADDR_W'(r_s1_idx);

    tzw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SENSORS),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (s1_wr),
        .i_waddr(s1_addr),
        .i_wdata(wr_entry),
        .i_re   (in_accept),
        .i_raddr(in_addr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        s1_in_range = 32'(r_s1_idx) < NUM_SENSORS;
        s1_deg = r_s1_raw[31:4];
        if (r_s1_fwd) begin
            s1_entry = r_fwd_entry;
        end else if (r_vld[s1_addr]) begin
            s1_entry = tzw_pkg::t_entry'(ram_rdata);
        end else begin
            s1_entry = '{zone: tzw_pkg::ZONE_START, degrees: '0};
        end
        s1_jump = (s1_deg >= s1_entry.degrees) ? (s1_deg - s1_entry.degrees)
                                               : (s1_entry.degrees - s1_deg);
        s1_wr = 1'b0;
        n_changed = 1'b0;
        wr_entry = s1_entry;
        wr_entry.degrees = s1_deg;
        if (!s1_in_range) begin
            n_status = tzw_pkg::ST_INVALID;
            n_zone = tzw_pkg::ZONE_START;
        end else if (r_s1_raw == r_invalid) begin
            n_status = tzw_pkg::ST_INVALID;
            n_zone = s1_entry.zone;
        end else if (s1_entry.zone != tzw_pkg::ZONE_START &&
                     s1_jump >= {{(DEG_W-8){1'b0}}, r_max_grad}) begin
            n_status = tzw_pkg::ST_REJECTED;
            n_zone = s1_entry.zone;
            s1_wr = s1_adv;
        end else begin
            n_status = tzw_pkg::ST_JUDGED;
            n_zone = tzw_pkg::next_zone(s1_entry.zone, s1_deg, r_high_thr, r_crit_thr, r_hyst);
            n_changed = n_zone != s1_entry.zone;
            wr_entry.zone = n_zone;
            s1_wr = s1_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_thr <= tzw_pkg::HIGH_THR_RST;
            r_crit_thr <= tzw_pkg::CRIT_THR_RST;
            r_hyst <= tzw_pkg::HYST_RST;
            r_max_grad <= tzw_pkg::MAX_GRAD_RST;
            r_invalid <= tzw_pkg::INVALID_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                tzw_pkg::CFG_HIGH_THR: r_high_thr <= i_cfg_data[7:0];
                tzw_pkg::CFG_CRIT_THR: r_crit_thr <= i_cfg_data[7:0];
                tzw_pkg::CFG_HYST: r_hyst <= i_cfg_data[3:0];
                tzw_pkg::CFG_MAX_GRAD: r_max_grad <= i_cfg_data[7:0];
                tzw_pkg::CFG_INVALID: r_invalid <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_vld <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_wr) begin
                r_vld[s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_idx <= i_s_axis_tuser;
            r_s1_raw <= i_s_axis_tdata;
            r_s1_fwd <= s1_wr && (s1_addr == in_addr);
            r_fwd_entry <= wr_entry;
        end
        if (s1_adv) begin
            r_out_id <= r_s1_idx;
            r_out_status <= n_status;
            r_out_zone <= n_zone;
            r_out_changed <= n_changed;
            r_out_deg <= s1_deg;
            r_out_tenth <= tzw_pkg::tenth_of(r_s1_raw[3:0]);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata = {5'b0, r_out_tenth, r_out_deg, r_out_changed, r_out_zone};
    assign o_m_axis_tuser = {r_out_status, r_out_id};

endmodule

FILE: rtl/tzw_checker.sv
module tzw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [31:0] i_s_axis_tdata,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic [3:0]  o_m_axis_tuser,
    input logic        i_cfg_wr_en,
    input logic [2:0]  i_cfg_index,
    input logic [31:0] i_cfg_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output transaction changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser[3:2] != 2'd3)
        else $error("unknown status");

    a_change_judged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[2] |->
            o_m_axis_tuser[3:2] == 2'd0 && o_m_axis_tdata[1:0] != 2'd0)
        else $error("zone change reported without a judgement");

    a_tenth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[34:31] <= 4'd9 && o_m_axis_tdata[39:35] == 5'd0)
        else $error("tenth degree out of range");

endmodule

bind temperature_zone_watcher_core tzw_checker u_tzw_checker (.*);
